[sv/atd_pkg.sv]
// Package for the accelerometer tilt and direction block.
// Holds widths, register map codes and the CORDIC angle table.
// No dependencies.
`default_nettype none
package atd_pkg;
    localparam int SAMPLE_BITS  = 16;
    localparam int CORDIC_STEPS = 28;
    localparam int PRESHIFT     = 15;
    // CORDIC datapath width: |sample| << 15, times the CORDIC gain (about 1.65), plus sign
    localparam int CW = SAMPLE_BITS + PRESHIFT + 3;
    localparam int AW = 32;   // Q30 angle with sign
    // Squared magnitude width: wide enough for the samples and for (gravity + tolerance)^2
    localparam int SQW = (2 * SAMPLE_BITS + 2 > 34) ? 2 * SAMPLE_BITS + 2 : 34;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [9:0]             t_angle;

    // Register indexes
    typedef enum logic [1:0] {
        REG_GRAVITY = 2'd0,
        REG_MAG_TOL = 2'd1,
        REG_DIR_TOL = 2'd2
    } t_reg_idx;

    // Direction classes
    typedef enum logic [2:0] {
        DIR_NEUTRAL = 3'd0,
        DIR_RIGHT   = 3'd1,
        DIR_LEFT    = 3'd2,
        DIR_FRONT   = 3'd3,
        DIR_BACK    = 3'd4,
        DIR_FLIPPED = 3'd5,
        DIR_ERROR   = 3'd6
    } t_dir;

    // Per-axis state handed from cell to cell
    typedef struct packed {
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [AW-1:0] ang;
    } t_cordic;

    // Side data that travels along with the CORDIC chain
    typedef struct packed {
        logic       valid;
        logic       z_pos;
        logic       z_zero;
        logic [1:0] ysgn;     // {neg, zero} of y
        logic [1:0] xsgn;     // {neg, zero} of x
        logic       ydz_neg;  // y and z of opposite sign
        logic       xdz_neg;
    } t_side;

    function automatic logic signed [AW-1:0] atan_q30(input int i);
        logic [31:0] t;
        case (i)
            0: t = 32'h3243F6A8;  1: t = 32'h1DAC6705;  2: t = 32'h0FADBAFC;
            3: t = 32'h07F56EA6;  4: t = 32'h03FEAB77;  5: t = 32'h01FFD55B;
            6: t = 32'h00FFFAAA;  7: t = 32'h007FFF55;  8: t = 32'h003FFFEA;
            9: t = 32'h001FFFFD; 10: t = 32'h000FFFFF; 11: t = 32'h0007FFFF;
            12: t = 32'h0003FFFF; 13: t = 32'h0001FFFF; 14: t = 32'h0000FFFF;
            15: t = 32'h00007FFF; 16: t = 32'h00003FFF; 17: t = 32'h00001FFF;
            18: t = 32'h00000FFF; 19: t = 32'h000007FF; 20: t = 32'h000003FF;
            21: t = 32'h000001FF; 22: t = 32'h000000FF; 23: t = 32'h0000007F;
            24: t = 32'h0000003F; 25: t = 32'h0000001F; 26: t = 32'h0000000F;
            default: t = 32'h00000007;
        endcase
        return signed'(t);
    endfunction
endpackage
`default_nettype wire

[sv/atd_if.sv]
// Valid/ready channel interfaces for samples and results.
// Depends on atd_pkg.
`default_nettype none
interface atd_in_if;
    logic                 valid;
    logic                 ready;
    atd_pkg::t_sample     accel_x;
    atd_pkg::t_sample     accel_y;
    atd_pkg::t_sample     accel_z;
    modport source (output valid, accel_x, accel_y, accel_z, input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface atd_out_if;
    logic                 valid;
    logic                 ready;
    atd_pkg::t_angle      x_angle;
    atd_pkg::t_angle      y_angle;
    logic                 magnitude_ok;
    logic [2:0]           direction;
    modport source (output valid, x_angle, y_angle, magnitude_ok, direction, input ready);
    modport sink   (input valid, x_angle, y_angle, magnitude_ok, direction, output ready);
endinterface
`default_nettype wire

[sv/atd_cell.sv]
// One CORDIC vectoring cell: a single rotation step on two axes with a register.
// Depends on atd_pkg.
`default_nettype none
module atd_cell (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [4:0]        i_step,
    input  wire atd_pkg::t_cordic  i_a,
    input  wire atd_pkg::t_cordic  i_b,
    input  wire atd_pkg::t_side    i_side,
    output atd_pkg::t_cordic       o_a,
    output atd_pkg::t_cordic       o_b,
    output atd_pkg::t_side         o_side
);
    import atd_pkg::*;

    t_cordic r_a, r_b;
    t_side   r_side;
    t_cordic n_a, n_b;
    logic signed [AW-1:0] w_atan;

    function automatic t_cordic rot(input t_cordic c, input logic [4:0] s,
                                    input logic signed [AW-1:0] t);
        t_cordic r;
        logic signed [CW-1:0] sx, sy;
        sx = c.cx >>> s;
        sy = c.cy >>> s;
        if (c.cy >= 0) begin
            r.cx = c.cx + sy; r.cy = c.cy - sx; r.ang = c.ang + t;
        end else begin
            r.cx = c.cx - sy; r.cy = c.cy + sx; r.ang = c.ang - t;
        end
        return r;
    endfunction

    assign w_atan = atan_q30(int'(i_step));

    // Rotate both axes in parallel
    always_comb begin
        n_a = rot(i_a, i_step, w_atan);
        n_b = rot(i_b, i_step, w_atan);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a    <= n_a;
            r_b    <= n_b;
            r_side <= i_side;
        end
    end

    assign o_a    = r_a;
    assign o_b    = r_b;
    assign o_side = r_side;
endmodule
`default_nettype wire

[sv/atd_finish.sv]
// Final stages: angle to degrees, quadrant fix-up and direction class.
// Depends on atd_pkg.
`default_nettype none
module atd_finish (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic signed [atd_pkg::AW-1:0] i_ang_x,
    input  wire logic signed [atd_pkg::AW-1:0] i_ang_y,
    input  wire atd_pkg::t_side           i_side,
    input  wire logic [8:0]               i_dir_tol,
    output atd_pkg::t_angle               o_x_angle,
    output atd_pkg::t_angle               o_y_angle,
    output logic                          o_ok,
    output logic [2:0]                    o_dir
);
    import atd_pkg::*;

    // Degrees: deg = ang*720000/(6283*2^31); use reciprocal multiply
    // q = floor(n / (6283*2^31)) with n = ang*720000 +/- 6283*2^30.
    // Reciprocal: t = n >> 31 (below 2^20), then q = (t * ceil(2^33/6283)) >> 33,
    // exact over that range.
    localparam logic [63:0] HALF  = 64'd6283 << 30;
    localparam logic [20:0] RECIP = 21'd1367171;

    // stage 1 registers: scaled numerators
    logic [63:0] r_nx, r_ny;
    logic        r_nx_pos, r_ny_pos;
    t_side       r_side1;
    // stage 2 registers: quotients
    logic [8:0]  r_qx, r_qy;
    t_side       r_side2;
    // stage 3: angles
    t_angle      r_xa, r_ya;
    t_side       r_side3;
    // stage 4: outputs
    t_angle      r_xo, r_yo;
    logic        r_ok;
    logic [2:0]  r_dir;

    function automatic logic [63:0] scale(input logic signed [AW-1:0] a, input logic neg,
                                          output logic pos);
        logic [31:0] m;
        logic [63:0] p;
        m = (a < 0) ? 32'd0 : 32'(a);
        p = 64'(m) * 64'd720000;
        if (!neg) begin
            pos = 1'b1; return p + HALF;
        end
        pos = (p > HALF);
        return p - HALF;
    endfunction

    // quotient below 91: drop the power-of-two part, then reciprocal multiply
    function automatic logic [8:0] qdiv(input logic [63:0] n);
        logic [19:0] t;
        logic [40:0] p;
        t = n[50:31];
        p = 41'(t) * 41'(RECIP);
        return 9'(p >> 33);
    endfunction

    function automatic t_angle axis(input logic [8:0] q, input logic [1:0] nsg,
                                    input logic dneg, input logic zz, input logic zp);
        t_angle a;
        if (zz) a = nsg[0] ? 10'sd0 : (nsg[1] ? -10'sd90 : 10'sd90);
        else if (nsg[0]) a = 10'sd0;
        else a = dneg ? -signed'(10'(q)) : signed'(10'(q));
        if (zp) a = nsg[1] ? a + 10'sd180 : a - 10'sd180;
        return a;
    endfunction

    function automatic logic [2:0] classify(input t_angle xa, input t_angle ya, input t_side s);
        logic [9:0] ax, ay, d;
        ax = xa[9] ? 10'(-xa) : 10'(xa);
        ay = ya[9] ? 10'(-ya) : 10'(ya);
        d  = (ax > ay) ? ax - ay : ay - ax;
        if (s.z_pos) return DIR_FLIPPED;
        if (!s.valid) return DIR_ERROR;
        if (d <= 10'(i_dir_tol)) return DIR_NEUTRAL;
        if (ax > ay) return (xa > 0) ? DIR_RIGHT : DIR_LEFT;
        return (ya > 0) ? DIR_FRONT : DIR_BACK;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            logic px, py;
            r_nx <= scale(i_ang_x, i_side.ydz_neg, px);
            r_ny <= scale(i_ang_y, i_side.xdz_neg, py);
            r_nx_pos <= px;
            r_ny_pos <= py;
            r_side1  <= i_side;
            r_qx <= r_nx_pos ? qdiv(r_nx) : 9'd0;
            r_qy <= r_ny_pos ? qdiv(r_ny) : 9'd0;
            r_side2 <= r_side1;
            if (r_side2.valid) begin
                r_xa <= axis(r_qx, r_side2.ysgn, r_side2.ydz_neg, r_side2.z_zero,
                             r_side2.z_pos);
                r_ya <= axis(r_qy, r_side2.xsgn, r_side2.xdz_neg, r_side2.z_zero,
                             r_side2.z_pos);
            end else begin
                r_xa <= '0; r_ya <= '0;
            end
            r_side3 <= r_side2;
            r_xo <= r_xa;
            r_yo <= r_ya;
            r_ok <= r_side3.valid;
            r_dir <= classify(r_xa, r_ya, r_side3);
        end
    end

    assign o_x_angle = r_xo;
    assign o_y_angle = r_yo;
    assign o_ok      = r_ok;
    assign o_dir     = r_dir;
endmodule
`default_nettype wire

[sv/accel_tilt_direction.sv]
// Top level of the accelerometer tilt and direction block.
// Depends on atd_pkg, atd_if, atd_cell and atd_finish.
//
// Use:
//  - Samples arrive on a valid/ready channel (accel_x/y/z, signed).
//  - Results leave on a valid/ready channel: x_angle, y_angle, magnitude_ok,
//    direction.
//  - Registers (gravity, magnitude tolerance, direction tolerance) sit on an
//    APB-style port at byte addresses 0, 4, 8; write only while idle.
// Timing:
//  - One sample per cycle while results are taken. Pipeline: two front stages
//    (squares, then magnitude compare), 28 CORDIC cells, four finish stages.
//  - The pipeline is a single enabled chain; when the receiver stalls with a
//    result waiting, the whole chain holds and input ready drops.
// Reset:
//  - Synchronous, active low; clears all valid flags and loads register
//    defaults (2048, 200, 10).
`default_nettype none
module accel_tilt_direction (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    atd_in_if.sink           i_in,
    atd_out_if.source        o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import atd_pkg::*;

    localparam int DEPTH = 2 + CORDIC_STEPS + 4;

    logic [15:0] r_grav, r_mtol;
    logic [8:0]  r_dtol;
    logic [DEPTH-1:0] r_vld;
    logic        w_en;
    t_reg_idx    w_idx;

    // Whole chain advances unless the last stage holds an untaken result
    assign w_en = !r_vld[DEPTH-1] || o_out.ready;
    assign i_in.ready = w_en;
    assign pready = 1'b1;
    assign w_idx = t_reg_idx'(paddr[3:2]);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav <= 16'd2048; r_mtol <= 16'd200; r_dtol <= 9'd10;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_GRAVITY: r_grav <= pwdata[15:0];
                REG_MAG_TOL: r_mtol <= pwdata[15:0];
                REG_DIR_TOL: r_dtol <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_GRAVITY: prdata = {16'd0, r_grav};
            REG_MAG_TOL: prdata = {16'd0, r_mtol};
            REG_DIR_TOL: prdata = {23'd0, r_dtol};
            default:     prdata = '0;
        endcase
    end

    // Valid flags along the chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (w_en) r_vld <= {r_vld[DEPTH-2:0], i_in.valid};
    end

    // Front stage 1: squares and magnitude bounds
    logic [SQW-1:0] r_sq, r_hi2, r_lo2;
    logic           r_lo_en;
    t_sample        r_x1, r_y1, r_z1;
    logic [SAMPLE_BITS-1:0] w_ax, w_ay, w_az;
    logic [16:0] w_hi;
    logic [15:0] w_lo;
    assign w_ax = i_in.accel_x[SAMPLE_BITS-1] ? SAMPLE_BITS'(-i_in.accel_x) : i_in.accel_x;
    assign w_ay = i_in.accel_y[SAMPLE_BITS-1] ? SAMPLE_BITS'(-i_in.accel_y) : i_in.accel_y;
    assign w_az = i_in.accel_z[SAMPLE_BITS-1] ? SAMPLE_BITS'(-i_in.accel_z) : i_in.accel_z;
    assign w_hi = 17'(r_grav) + 17'(r_mtol);
    assign w_lo = r_grav - r_mtol;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq  <= SQW'(w_ax * w_ax) + SQW'(w_ay * w_ay) + SQW'(w_az * w_az);
            r_hi2 <= SQW'(w_hi * w_hi);
            r_lo2 <= SQW'(w_lo * w_lo);
            r_lo_en <= r_grav > r_mtol;
            r_x1 <= i_in.accel_x; r_y1 <= i_in.accel_y; r_z1 <= i_in.accel_z;
        end
    end

    // Front stage 2: validity and CORDIC seeds
    t_cordic r_ca, r_cb;
    t_side   r_s2;
    function automatic logic [CW-1:0] mag(input t_sample v);
        logic [SAMPLE_BITS-1:0] m;
        m = v[SAMPLE_BITS-1] ? SAMPLE_BITS'(-v) : v;
        return CW'(m) << PRESHIFT;
    endfunction
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ca.cx <= signed'(mag(r_z1)); r_ca.cy <= signed'(mag(r_y1)); r_ca.ang <= '0;
            r_cb.cx <= signed'(mag(r_z1)); r_cb.cy <= signed'(mag(r_x1)); r_cb.ang <= '0;
            r_s2.valid   <= (r_sq <= r_hi2) && !(r_lo_en && r_sq < r_lo2);
            r_s2.z_pos   <= !r_z1[SAMPLE_BITS-1] && (r_z1 != 0);
            r_s2.z_zero  <= r_z1 == 0;
            r_s2.ysgn    <= {r_y1[SAMPLE_BITS-1], r_y1 == 0};
            r_s2.xsgn    <= {r_x1[SAMPLE_BITS-1], r_x1 == 0};
            r_s2.ydz_neg <= r_y1[SAMPLE_BITS-1] != r_z1[SAMPLE_BITS-1];
            r_s2.xdz_neg <= r_x1[SAMPLE_BITS-1] != r_z1[SAMPLE_BITS-1];
        end
    end

    // CORDIC cell chain
    t_cordic c_a [0:CORDIC_STEPS];
    t_cordic c_b [0:CORDIC_STEPS];
    t_side   c_s [0:CORDIC_STEPS];
    assign c_a[0] = r_ca;
    assign c_b[0] = r_cb;
    assign c_s[0] = r_s2;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        atd_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_step (5'(g)),
            .i_a    (c_a[g]),
            .i_b    (c_b[g]),
            .i_side (c_s[g]),
            .o_a    (c_a[g+1]),
            .o_b    (c_b[g+1]),
            .o_side (c_s[g+1])
        );
    end

    atd_finish u_finish (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_ang_x   (c_a[CORDIC_STEPS].ang),
        .i_ang_y   (c_b[CORDIC_STEPS].ang),
        .i_side    (c_s[CORDIC_STEPS]),
        .i_dir_tol (r_dtol),
        .o_x_angle (o_out.x_angle),
        .o_y_angle (o_out.y_angle),
        .o_ok      (o_out.magnitude_ok),
        .o_dir     (o_out.direction)
    );

    assign o_out.valid = r_vld[DEPTH-1];
endmodule
`default_nettype wire

[test/tb_tilt_checker.sv]
// Checker for the accelerometer tilt and direction block: watches both channels,
// predicts each result from the accepted sample and the current registers, compares.
// Depends on atd_pkg and atd_if.
`default_nettype none
module tb_tilt_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    atd_in_if.sink           i_mon_in,
    atd_out_if.sink          i_mon_out,
    input  wire logic [15:0] i_gravity,
    input  wire logic [15:0] i_mag_tol,
    input  wire logic [8:0]  i_dir_tol,
    output int               o_fail_count,
    output int               o_pending
);
    import atd_pkg::*;

    typedef struct packed {
        t_angle     x_angle;
        t_angle     y_angle;
        logic       magnitude_ok;
        logic [2:0] direction;
    } t_tilt_result;

    t_tilt_result expected_tilts[$];
    int           mismatches;

    // Q30 arctangent table, own copy
    localparam longint ATAN_TAB[28] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB77,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
        64'h0000001F, 64'h0000000F, 64'h00000007};

    // Rounded atan(num/den) in degrees; den nonzero
    function automatic int round_atan_deg(input longint num, input longint den);
        longint a, b, cx, cy, ang, sx, sy, half, full, n;
        bit neg;
        a = num < 0 ? -num : num;
        b = den < 0 ? -den : den;
        if (a == 0) return 0;
        cx = b <<< 15;
        cy = a <<< 15;
        ang = 0;
        for (int i = 0; i < 28; i++) begin
            sx = cx >>> i;   // arithmetic shift floors
            sy = cy >>> i;
            if (cy >= 0) begin
                cx = cx + sy; cy = cy - sx; ang += ATAN_TAB[i];
            end else begin
                cx = cx - sy; cy = cy + sx; ang -= ATAN_TAB[i];
            end
        end
        if (ang < 0) ang = 0;
        neg  = (num < 0) != (den < 0);
        half = 64'd6283 <<< 30;
        full = 64'd6283 <<< 31;
        if (!neg) return int'((ang * 720000 + half) / full);
        n = ang * 720000 - half;
        return n > 0 ? -int'(n / full) : 0;
    endfunction

    function automatic int tilt_for_axis(input longint num, input longint z);
        int ang;
        if (z != 0) ang = round_atan_deg(num, z);
        else        ang = num > 0 ? 90 : (num < 0 ? -90 : 0);
        if (z > 0)  ang = num < 0 ? ang + 180 : ang - 180;
        return ang;
    endfunction

    function automatic t_tilt_result predict_tilt(input t_sample sx, input t_sample sy,
                                                  input t_sample sz);
        t_tilt_result r;
        longint x, y, z, sq, hi, lo;
        int xa, ya, ax, ay, d;
        bit ok;
        t_dir dir;
        x = sx; y = sy; z = sz;
        sq = x*x + y*y + z*z;
        hi = longint'(i_gravity) + longint'(i_mag_tol);
        ok = sq <= hi*hi;
        if (i_gravity > i_mag_tol) begin
            lo = longint'(i_gravity) - longint'(i_mag_tol);
            if (sq < lo*lo) ok = 0;
        end
        xa = 0; ya = 0;
        if (ok) begin
            xa = tilt_for_axis(y, z);
            ya = tilt_for_axis(x, z);
        end
        if (z > 0)      dir = DIR_FLIPPED;
        else if (!ok)   dir = DIR_ERROR;
        else begin
            ax = xa < 0 ? -xa : xa;
            ay = ya < 0 ? -ya : ya;
            d  = ax > ay ? ax - ay : ay - ax;
            if (d > int'(i_dir_tol)) begin
                if (ax > ay) dir = xa > 0 ? DIR_RIGHT : DIR_LEFT;
                else         dir = ya > 0 ? DIR_FRONT : DIR_BACK;
            end else dir = DIR_NEUTRAL;
        end
        r.x_angle = t_angle'(xa);
        r.y_angle = t_angle'(ya);
        r.magnitude_ok = ok;
        r.direction = dir;
        return r;
    endfunction

    function automatic void note_mismatch(input string what, input int exp_v, input int act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %0d got %0d at %0t", what, exp_v, act_v, $time);
    endfunction

    // Sample transactions in, result transactions out
    always @(posedge i_clk) begin
        t_tilt_result want;
        if (!i_rst_n) begin
            expected_tilts.delete();
        end else begin
            if (i_mon_in.valid && i_mon_in.ready)
                expected_tilts.push_back(predict_tilt(i_mon_in.accel_x, i_mon_in.accel_y,
                                                      i_mon_in.accel_z));
            if (i_mon_out.valid && i_mon_out.ready) begin
                if (expected_tilts.size() == 0) begin
                    note_mismatch("unexpected result", 0, 1);
                end else begin
                    want = expected_tilts.pop_front();
                    if (want.x_angle != i_mon_out.x_angle)
                        note_mismatch("x_angle", want.x_angle, i_mon_out.x_angle);
                    if (want.y_angle != i_mon_out.y_angle)
                        note_mismatch("y_angle", want.y_angle, i_mon_out.y_angle);
                    if (want.magnitude_ok != i_mon_out.magnitude_ok)
                        note_mismatch("magnitude_ok", want.magnitude_ok,
                                      i_mon_out.magnitude_ok);
                    if (want.direction != i_mon_out.direction)
                        note_mismatch("direction", want.direction, i_mon_out.direction);
                end
            end
        end
    end

    assign o_fail_count = mismatches;
    assign o_pending    = expected_tilts.size();

    initial mismatches = 0;
endmodule
`default_nettype wire

[test/tb_top.sv]
// Top of the tilt block testbench: clock, reset, register writes, sample stimulus
// and result stalls; verdict from the checker's count. Depends on atd_pkg, atd_if,
// tb_tilt_checker and the block.
`default_nettype none
module tb_top;
    import atd_pkg::*;

    logic        i_clk, i_rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;
    logic [15:0] gravity_reg, mag_tol_reg;
    logic [8:0]  dir_tol_reg;
    int          fail_count, pending;
    bit          calm_tail;   // no idling near the end
    bit          long_hold;

    atd_in_if  sample_ch();
    atd_out_if tilt_ch();

    accel_tilt_direction uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(sample_ch.sink), .o_out(tilt_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    tb_tilt_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_mon_in(sample_ch.sink),
        .i_mon_out(tilt_ch.sink), .i_gravity(gravity_reg), .i_mag_tol(mag_tol_reg),
        .i_dir_tol(dir_tol_reg), .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit
    initial begin
        #3000000;
        $display("tb_top NOT OK");
        $finish;
    end

    // Register write: setup then access cycle
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            REG_GRAVITY: gravity_reg = val[15:0];
            REG_MAG_TOL: mag_tol_reg = val[15:0];
            default:     dir_tol_reg = val[8:0];
        endcase
    endtask

    task automatic send_sample(input t_sample x, input t_sample y, input t_sample z);
        int gap;
        if (!calm_tail && $urandom_range(0, 5) == 0) begin
            sample_ch.valid <= 0;
            gap = $urandom_range(1, 18);
            repeat (gap) @(posedge i_clk);
        end
        sample_ch.valid   <= 1;
        sample_ch.accel_x <= x;
        sample_ch.accel_y <= y;
        sample_ch.accel_z <= z;
        do @(posedge i_clk); while (!sample_ch.ready);
    endtask

    task automatic drain;
        sample_ch.valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // Sample of roughly the given magnitude in a random direction, z of either sign
    task automatic send_near(input int mag);
        int x, y, z;
        real th, ph;
        th = ($urandom_range(0, 10000) / 10000.0) * 3.1415;
        ph = ($urandom_range(0, 10000) / 10000.0) * 6.283;
        x = $rtoi(mag * $sin(th) * $cos(ph)) + $urandom_range(0, 20) - 10;
        y = $rtoi(mag * $sin(th) * $sin(ph)) + $urandom_range(0, 20) - 10;
        z = -$rtoi(mag * $cos(th));
        if ($urandom_range(0, 4) == 0) z = -z;
        send_sample(t_sample'(x), t_sample'(y), t_sample'(z));
    endtask

    // Receiver: random stall bursts, one long hold-off
    initial begin
        int gap;
        tilt_ch.ready = 0;
        @(posedge i_clk);
        forever begin
            if (long_hold) begin
                tilt_ch.ready <= 0;
                repeat (200) @(posedge i_clk);
                long_hold = 0;
            end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
                tilt_ch.ready <= 0;
                gap = $urandom_range(1, 18);
                repeat (gap) @(posedge i_clk);
            end else begin
                tilt_ch.ready <= 1;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        int n;
        t_sample x, y, z;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        sample_ch.valid = 0; sample_ch.accel_x = 0; sample_ch.accel_y = 0;
        sample_ch.accel_z = 0;
        gravity_reg = 2048; mag_tol_reg = 200; dir_tol_reg = 10;
        calm_tail = 0; long_hold = 0;
        i_rst_n = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: default registers
        send_sample(0, 0, -2048);        // level
        send_sample(0, 0, 2048);         // flipped
        send_sample(2048, 0, 0);         // z zero, positive numerator
        send_sample(-2048, 0, 0);
        send_sample(0, 2048, 0);
        send_sample(0, -2048, 0);
        send_sample(1000, 0, -1800);     // back
        send_sample(-1000, 0, -1800);    // front
        send_sample(0, 1000, -1800);     // left
        send_sample(0, -1000, -1800);    // right
        send_sample(700, 690, -1800);    // near equal tilt: neutral
        send_sample(-1000, 1000, 1500);  // z positive, mixed signs
        send_sample(1000, -1000, 1500);
        send_sample(5, 3, -10);          // too small: error
        send_sample(-32768, -32768, -32768);
        send_sample(32767, 32767, 32767);
        send_sample(-32768, 32767, 0);
        drain();

        // Extremes: whole range accepted, no lower bound
        write_reg(REG_GRAVITY, 32'hFFFF_0000);
        write_reg(REG_MAG_TOL, 32'h0000_FFFF);
        write_reg(REG_DIR_TOL, 9'd0);
        send_sample(-32768, -32768, -32768);
        send_sample(32767, -32768, 32767);
        send_sample(1, 0, -1);
        send_sample(0, 0, 0);
        send_sample(0, 0, -1);
        send_sample(3, 3, -5);
        drain();

        // Random phases with various register settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_reg(REG_GRAVITY, 2048); write_reg(REG_MAG_TOL, 200);
                         write_reg(REG_DIR_TOL, 360); end
                1: begin write_reg(REG_GRAVITY, 16384); write_reg(REG_MAG_TOL, 0);
                         write_reg(REG_DIR_TOL, 511); end
                2: begin write_reg(REG_GRAVITY, 65535); write_reg(REG_MAG_TOL, 65535);
                         write_reg(REG_DIR_TOL, $urandom_range(0, 30)); end
                3: begin write_reg(REG_GRAVITY, 0); write_reg(REG_MAG_TOL, 60000);
                         write_reg(REG_DIR_TOL, 1); end
                4: begin write_reg(REG_GRAVITY, 4096); write_reg(REG_MAG_TOL, 400);
                         write_reg(REG_DIR_TOL, 10); end
                default: begin write_reg(REG_GRAVITY, 2048); write_reg(REG_MAG_TOL, 300);
                         write_reg(REG_DIR_TOL, 5); calm_tail = 1; end
            endcase
            if (ph == 4) long_hold = 1;
            for (n = 0; n < 240; n++) begin
                if ($urandom_range(0, 3) != 0 && gravity_reg != 0 && gravity_reg < 20000)
                    send_near(gravity_reg + $urandom_range(0, 2*mag_tol_reg + 40)
                              - mag_tol_reg - 20);
                else begin
                    x = t_sample'($urandom); y = t_sample'($urandom);
                    z = $urandom_range(0, 7) == 0 ? t_sample'(0) : t_sample'($urandom);
                    send_sample(x, y, z);
                end
            end
            drain();
        end

        if (fail_count == 0) $display("tb_top OK");
        else                 $display("tb_top NOT OK");
        $finish;
    end
endmodule
`default_nettype wire

[filelist.f]
sv/atd_pkg.sv
sv/atd_if.sv
sv/atd_cell.sv
sv/atd_finish.sv
sv/accel_tilt_direction.sv
test/tb_tilt_checker.sv
test/tb_top.sv
